### sv/btps_pkg.sv
// Package for the buzzer tone pattern sequencer: opcodes, result struct,
// pattern ROM tables and beep timing constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package btps_pkg;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_PLAY    = 2'd1,
    OP_COUNT   = 2'd2,
    OP_STOP    = 2'd3
  } op_e;

  typedef struct packed {
    logic [11:0] tone_hz;
    logic        tone_on;
    logic        busy_res;
    logic [3:0]  step_index;
  } res_t;

  localparam int unsigned NUM_PATTERNS = 12;
  localparam int unsigned ROM_COLS     = 5;

  localparam logic [11:0] BEEP_HZ = 12'd2700;
  localparam logic [9:0]  BEEP_MS = 10'd70;
  localparam logic [9:0]  GAP_MS  = 10'd90;

  localparam logic [11:0] ROM_HZ [NUM_PATTERNS][ROM_COLS] = '{
    '{12'd0,    12'd0,    12'd0,    12'd0,    12'd0},
    '{12'd1500, 12'd2000, 12'd2700, 12'd0,    12'd0},
    '{12'd2700, 12'd0,    12'd0,    12'd0,    12'd0},
    '{12'd2700, 12'd0,    12'd0,    12'd0,    12'd0},
    '{12'd2400, 12'd0,    12'd2400, 12'd0,    12'd0},
    '{12'd2200, 12'd2700, 12'd0,    12'd0,    12'd0},
    '{12'd600,  12'd0,    12'd0,    12'd0,    12'd0},
    '{12'd2200, 12'd0,    12'd1900, 12'd0,    12'd1600},
    '{12'd1200, 12'd900,  12'd600,  12'd0,    12'd0},
    '{12'd1800, 12'd2200, 12'd2700, 12'd3200, 12'd0},
    '{12'd3200, 12'd2700, 12'd2200, 12'd1800, 12'd0},
    '{12'd2700, 12'd0,    12'd0,    12'd0,    12'd0}
  };

  localparam logic [9:0] ROM_MS [NUM_PATTERNS][ROM_COLS] = '{
    '{10'd0,    10'd0,   10'd0,   10'd0,  10'd0},
    '{10'd40,   10'd40,  10'd80,  10'd0,  10'd0},
    '{10'd80,   10'd0,   10'd0,   10'd0,  10'd0},
    '{10'd60,   10'd80,  10'd0,   10'd0,  10'd0},
    '{10'd40,   10'd40,  10'd40,  10'd0,  10'd0},
    '{10'd60,   10'd90,  10'd0,   10'd0,  10'd0},
    '{10'd300,  10'd0,   10'd0,   10'd0,  10'd0},
    '{10'd80,   10'd80,  10'd80,  10'd80, 10'd120},
    '{10'd250,  10'd250, 10'd400, 10'd0,  10'd0},
    '{10'd60,   10'd60,  10'd60,  10'd90, 10'd0},
    '{10'd60,   10'd60,  10'd60,  10'd90, 10'd0},
    '{10'd1000, 10'd0,   10'd0,   10'd0,  10'd0}
  };

  localparam logic [3:0] ROM_LEN [NUM_PATTERNS] = '{
    4'd0, 4'd3, 4'd1, 4'd2, 4'd3, 4'd2, 4'd1, 4'd5, 4'd3, 4'd4, 4'd4, 4'd1
  };

endpackage

`default_nettype wire

### sv/btps_seq.sv
// Sequencer state and combinational update: decodes one command or tick,
// updates the playback registers and forms the result. Uses btps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module btps_seq #(
  parameter int unsigned STEPS_PER_PATTERN = 12,
  parameter int unsigned MAX_BEEPS         = 5
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             xfer_i,
  input  wire logic [1:0]       opcode_i,
  input  wire logic [3:0]       pattern_id_i,
  input  wire logic [7:0]       beep_count_i,
  output btps_pkg::res_t        res_o
);

  localparam int unsigned HalfSteps = STEPS_PER_PATTERN / 2;
  localparam int unsigned BeepCap   = (MAX_BEEPS < HalfSteps) ? MAX_BEEPS : HalfSteps;
  localparam logic [7:0]  BeepCapW  = 8'(BeepCap);

  logic        count_mode_q, count_mode_d;
  logic [3:0]  pattern_sel_q, pattern_sel_d;
  logic [3:0]  step_pos_q, step_pos_d;
  logic [2:0]  beeps_total_q, beeps_total_d;
  logic [9:0]  ms_left_q, ms_left_d;
  logic        playing_q, playing_d;
  logic        sounding_q, sounding_d;
  logic [11:0] freq_now_q, freq_now_d;

  // command decode result, before the step load is applied
  logic [9:0]  ms_left_upd;
  logic        playing_upd;

  // step load request
  logic        ld_en;
  logic [4:0]  ld_idx;
  logic        go_idle;
  logic [3:0]  ld_len;
  logic        ld_stop;
  logic [11:0] ld_hz;
  logic [9:0]  ld_ms;
  logic [7:0]  n_cap;
  logic        pid_ok;

  always_comb begin
    n_cap  = (beep_count_i > BeepCapW) ? BeepCapW : beep_count_i;
    pid_ok = (pattern_id_i != 4'd0) &&
             (pattern_id_i < 4'(btps_pkg::NUM_PATTERNS));
  end

  always_comb begin
    count_mode_d  = count_mode_q;
    pattern_sel_d = pattern_sel_q;
    beeps_total_d = beeps_total_q;
    ms_left_upd   = ms_left_q;
    playing_upd   = playing_q;
    go_idle       = 1'b0;
    ld_en         = 1'b0;
    ld_idx        = 5'd0;

    if (xfer_i) begin
      case (btps_pkg::op_e'(opcode_i))
        btps_pkg::OP_TICK: begin
          if (playing_q) begin
            if (ms_left_q > 10'd1) begin
              ms_left_upd = ms_left_q - 10'd1;
            end else begin
              ld_en  = 1'b1;
              ld_idx = {1'b0, step_pos_q} + 5'd1;
            end
          end
        end
        btps_pkg::OP_PLAY: begin
          if (!pid_ok) begin
            go_idle = 1'b1;
          end else begin
            count_mode_d  = 1'b0;
            pattern_sel_d = pattern_id_i;
            playing_upd   = 1'b1;
            ld_en         = 1'b1;
          end
        end
        btps_pkg::OP_COUNT: begin
          if (beep_count_i == 8'd0) begin
            go_idle = 1'b1;
          end else begin
            count_mode_d  = 1'b1;
            beeps_total_d = n_cap[2:0];
            playing_upd   = 1'b1;
            ld_en         = 1'b1;
          end
        end
        default: go_idle = 1'b1;
      endcase
    end
  end

  // Step fetch uses the already-updated mode, pattern and beep count.
  always_comb begin
    ld_hz = 12'd0;
    ld_ms = 10'd0;
    if (count_mode_d) begin
      ld_len  = {beeps_total_d, 1'b0};
      ld_stop = ({1'b0, ld_len} <= ld_idx);
      ld_hz   = ld_idx[0] ? 12'd0 : btps_pkg::BEEP_HZ;
      ld_ms   = ld_idx[0] ? btps_pkg::GAP_MS : btps_pkg::BEEP_MS;
    end else begin
      ld_len  = (pattern_sel_d < 4'(btps_pkg::NUM_PATTERNS)) ?
                btps_pkg::ROM_LEN[pattern_sel_d] : 4'd0;
      ld_stop = ({1'b0, ld_len} <= ld_idx) ||
                (ld_idx >= 5'(btps_pkg::ROM_COLS));
      if (!ld_stop) begin
        ld_hz = btps_pkg::ROM_HZ[pattern_sel_d][ld_idx[2:0]];
        ld_ms = btps_pkg::ROM_MS[pattern_sel_d][ld_idx[2:0]];
      end
    end
  end

  always_comb begin
    playing_d  = playing_upd;
    ms_left_d  = ms_left_upd;
    step_pos_d = step_pos_q;
    sounding_d = sounding_q;
    freq_now_d = freq_now_q;
    if (go_idle || (ld_en && ld_stop)) begin
      playing_d  = 1'b0;
      sounding_d = 1'b0;
      freq_now_d = 12'd0;
      ms_left_d  = 10'd0;
    end else if (ld_en) begin
      step_pos_d = ld_idx[3:0];
      freq_now_d = ld_hz;
      sounding_d = (ld_hz != 12'd0);
      ms_left_d  = ld_ms;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_mode_q  <= 1'b0;
      pattern_sel_q <= 4'd0;
      step_pos_q    <= 4'd0;
      beeps_total_q <= 3'd0;
      ms_left_q     <= 10'd0;
      playing_q     <= 1'b0;
      sounding_q    <= 1'b0;
      freq_now_q    <= 12'd0;
    end else begin
      count_mode_q  <= count_mode_d;
      pattern_sel_q <= pattern_sel_d;
      step_pos_q    <= step_pos_d;
      beeps_total_q <= beeps_total_d;
      ms_left_q     <= ms_left_d;
      playing_q     <= playing_d;
      sounding_q    <= sounding_d;
      freq_now_q    <= freq_now_d;
    end
  end

  // result reports the state after this update
  always_comb begin
    res_o.tone_on    = playing_d && sounding_d;
    res_o.tone_hz    = res_o.tone_on ? freq_now_d : 12'd0;
    res_o.busy_res   = playing_d;
    res_o.step_index = playing_d ? step_pos_d : 4'd0;
  end

endmodule

`default_nettype wire

### sv/btps_res_buf.sv
// Two-entry result buffer: output register plus skid slot, so a new
// transfer is taken while a result waits. Uses btps_pkg::res_t.
`timescale 1ns / 1ps
`default_nettype none

module btps_res_buf (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire btps_pkg::res_t res_i,
  output logic                full_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output btps_pkg::res_t      res_o
);

  btps_pkg::res_t slot0_q, slot0_d;
  btps_pkg::res_t slot1_q, slot1_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign full_o      = (cnt_q == 2'd2);
  assign res_o       = slot0_q;
  assign pop         = out_valid_o && !out_stall_i;

  always_comb begin
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    cnt_d   = cnt_q;
    case (cnt_q)
      2'd0: begin
        if (push_i) begin
          slot0_d = res_i;
          cnt_d   = 2'd1;
        end
      end
      2'd1: begin
        if (push_i && pop) begin
          slot0_d = res_i;
        end else if (push_i) begin
          slot1_d = res_i;
          cnt_d   = 2'd2;
        end else if (pop) begin
          cnt_d = 2'd0;
        end
      end
      2'd2: begin
        if (pop) begin
          slot0_d = slot1_q;
          cnt_d   = 2'd1;
        end
      end
      default: cnt_d = 2'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

endmodule

`default_nettype wire

### sv/buzzer_tone_pattern_sequencer_core.sv
// Buzzer tone pattern sequencer top level.
// Input channel: in_valid_i / in_stall_o with opcode_i (tick, play pattern,
// play count, stop), pattern_id_i and beep_count_i.
// Output channel: out_valid_o / out_stall_i with tone_hz_o, tone_on_o,
// busy_res_o and step_index_o; one result per input transfer, in order.
// The result of a transfer is registered into the output buffer at the
// transfer edge. Throughput: one item per cycle while in_stall_o is low;
// the state update is a single pass through the step decode and pattern ROM lookup.
// A two-entry result buffer sits at the output: with the receiver stalling,
// one more transfer is taken, then in_stall_o rises until a result drains.
// Reset (rst_ni low, asynchronous) empties the buffer and returns the
// sequencer to idle: nothing playing, tone off, step 0.
// Depends on btps_pkg, btps_seq and btps_res_buf.
`timescale 1ns / 1ps
`default_nettype none

module buzzer_tone_pattern_sequencer_core #(
  parameter int unsigned STEPS_PER_PATTERN = 12,
  parameter int unsigned MAX_BEEPS         = 5
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [3:0]  pattern_id_i,
  input  wire logic [7:0]  beep_count_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [11:0]      tone_hz_o,
  output logic             tone_on_o,
  output logic             busy_res_o,
  output logic [3:0]       step_index_o
);

  logic           xfer;
  logic           buf_full;
  btps_pkg::res_t res_new;
  btps_pkg::res_t res_out;

  assign in_stall_o = buf_full;
  assign xfer       = in_valid_i && !buf_full;

  btps_seq #(
    .STEPS_PER_PATTERN (STEPS_PER_PATTERN),
    .MAX_BEEPS         (MAX_BEEPS)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .xfer_i       (xfer),
    .opcode_i     (opcode_i),
    .pattern_id_i (pattern_id_i),
    .beep_count_i (beep_count_i),
    .res_o        (res_new)
  );

  btps_res_buf u_res_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (xfer),
    .res_i       (res_new),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_out)
  );

  assign tone_hz_o    = res_out.tone_hz;
  assign tone_on_o    = res_out.tone_on;
  assign busy_res_o   = res_out.busy_res;
  assign step_index_o = res_out.step_index;

endmodule

`default_nettype wire

### sv/btps_checker.sv
// Port-level checks for the buzzer tone pattern sequencer, bound to the
// top level. Sees only the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module btps_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [11:0] tone_hz_o,
  input wire logic        tone_on_o,
  input wire logic        busy_res_o,
  input wire logic [3:0]  step_index_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(tone_hz_o) &&
    $stable(step_index_o) && $stable(busy_res_o))
    else $error("stalled result dropped or changed");

  // idle results carry no tone and step 0
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !busy_res_o |->
    tone_hz_o == 12'd0 && !tone_on_o && step_index_o == 4'd0)
    else $error("idle result not quiet");

  a_tone_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && tone_on_o |-> busy_res_o && tone_hz_o != 12'd0)
    else $error("tone on without playback or frequency");

  // a transfer into an empty output shows its result next cycle
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("result missing one cycle after transfer");

endmodule

bind buzzer_tone_pattern_sequencer_core btps_checker u_btps_checker (.*);

`default_nettype wire

### tb/sv/tb_top.sv
// Testbench for buzzer_tone_pattern_sequencer_core: sends ticks and play, count and
// stop commands, and checks every result against an in-bench model of the player.
// Depends on btps_pkg and the RTL of the sequencer.
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int RANDOM_ITEMS = 600;
  localparam int MAX_REPORTS  = 10;
  localparam int STEPS        = 12;
  localparam int BEEP_CAP     = 5;
  localparam int PATTERNS     = 12;
  localparam int COLS         = 5;
  localparam int TONE_BEEP_HZ = 2700;
  localparam int BEEP_ON_MS   = 70;
  localparam int BEEP_OFF_MS  = 90;

  localparam int PAT_LEN [PATTERNS] = '{0, 3, 1, 2, 3, 2, 1, 5, 3, 4, 4, 1};

  localparam int PAT_HZ [PATTERNS][COLS] = '{
    '{0,    0,    0,    0,    0},
    '{1500, 2000, 2700, 0,    0},
    '{2700, 0,    0,    0,    0},
    '{2700, 0,    0,    0,    0},
    '{2400, 0,    2400, 0,    0},
    '{2200, 2700, 0,    0,    0},
    '{600,  0,    0,    0,    0},
    '{2200, 0,    1900, 0,    1600},
    '{1200, 900,  600,  0,    0},
    '{1800, 2200, 2700, 3200, 0},
    '{3200, 2700, 2200, 1800, 0},
    '{2700, 0,    0,    0,    0}
  };

  localparam int PAT_MS [PATTERNS][COLS] = '{
    '{0,    0,   0,   0,  0},
    '{40,   40,  80,  0,  0},
    '{80,   0,   0,   0,  0},
    '{60,   80,  0,   0,  0},
    '{40,   40,  40,  0,  0},
    '{60,   90,  0,   0,  0},
    '{300,  0,   0,   0,  0},
    '{80,   80,  80,  80, 120},
    '{250,  250, 400, 0,  0},
    '{60,   60,  60,  90, 0},
    '{60,   60,  60,  90, 0},
    '{1000, 0,   0,   0,  0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid;
  wire         in_stall;
  logic [1:0]  opcode;
  logic [3:0]  pattern_id;
  logic [7:0]  beep_count;
  wire         out_valid;
  logic        out_stall = 1'b0;
  wire  [11:0] tone_hz;
  wire         tone_on;
  wire         busy_res;
  wire  [3:0]  step_index;

  // player model state
  logic        pl_count_mode;
  logic        pl_active;
  logic        pl_tone;
  logic [3:0]  pl_pattern;
  logic [3:0]  pl_step;
  logic [2:0]  pl_beeps;
  logic [9:0]  pl_ms;
  logic [11:0] pl_hz;

  btps_pkg::res_t pending_tones [$];
  int   errors     = 0;
  int   items_sent = 0;
  int   cycles     = 0;
  bit   tx_steady  = 1'b0;
  bit   rx_steady  = 1'b0;
  int   hold_len   = 0;
  int   hold_req   = 0;
  int   hold_seen  = 0;
  int   hold_left  = 0;

  buzzer_tone_pattern_sequencer_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .opcode_i     (opcode),
    .pattern_id_i (pattern_id),
    .beep_count_i (beep_count),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .tone_hz_o    (tone_hz),
    .tone_on_o    (tone_on),
    .busy_res_o   (busy_res),
    .step_index_o (step_index)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------- player model

  task automatic go_silent();
    pl_active = 1'b0;
    pl_tone   = 1'b0;
    pl_hz     = '0;
    pl_ms     = '0;
  endtask

  task automatic enter_step(int idx);
    int len, hz, ms;
    if (pl_count_mode) len = 2 * pl_beeps;
    else len = (pl_pattern < PATTERNS) ? PAT_LEN[pl_pattern] : 0;
    if (!pl_active || idx >= len || idx >= (pl_count_mode ? 16 : COLS)) begin
      go_silent();
    end else begin
      if (pl_count_mode) begin
        // even steps beep, odd steps are the silence after each beep
        hz = idx[0] ? 0 : TONE_BEEP_HZ;
        ms = idx[0] ? BEEP_OFF_MS : BEEP_ON_MS;
      end else begin
        hz = PAT_HZ[pl_pattern][idx];
        ms = PAT_MS[pl_pattern][idx];
      end
      pl_step = idx[3:0];
      pl_hz   = hz[11:0];
      pl_tone = (hz != 0);
      pl_ms   = ms[9:0];
    end
  endtask

  task automatic play_update(btps_pkg::op_e op, logic [3:0] pid, logic [7:0] cnt,
                             output btps_pkg::res_t r);
    int n;
    case (op)
      btps_pkg::OP_TICK: begin
        if (pl_active) begin
          if (pl_ms > 1) pl_ms = pl_ms - 10'd1;
          else enter_step(int'(pl_step) + 1);
        end
      end
      btps_pkg::OP_PLAY: begin
        if (pid == 0 || pid >= PATTERNS) begin
          go_silent();
        end else begin
          pl_count_mode = 1'b0;
          pl_pattern    = pid;
          pl_active     = 1'b1;
          enter_step(0);
        end
      end
      btps_pkg::OP_COUNT: begin
        if (cnt == 0) begin
          go_silent();
        end else begin
          n = (cnt > BEEP_CAP) ? BEEP_CAP : int'(cnt);
          if (n > STEPS / 2) n = STEPS / 2;
          pl_count_mode = 1'b1;
          pl_beeps      = n[2:0];
          pl_active     = 1'b1;
          enter_step(0);
        end
      end
      default: go_silent();
    endcase
    r.tone_hz    = (pl_active && pl_tone) ? pl_hz : 12'd0;
    r.tone_on    = pl_active && pl_tone;
    r.busy_res   = pl_active;
    r.step_index = pl_active ? pl_step : 4'd0;
  endtask

  // ---------------------------------------------------------------- channels

  task automatic send_item(btps_pkg::op_e op, logic [3:0] pid, logic [7:0] cnt);
    btps_pkg::res_t r;
    while (!tx_steady && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    pattern_id <= pid;
    beep_count <= cnt;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    play_update(op, pid, cnt, r);
    pending_tones.push_back(r);
    items_sent++;
  endtask

  task automatic send_tick();
    send_item(btps_pkg::OP_TICK, 4'($urandom_range(15)), 8'($urandom_range(255)));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_tones.size() != 0) @(posedge clk_i);
  endtask

  // command, then ticks while the model still plays (up to cap), then zero to two more ticks
  task automatic play_to_end(btps_pkg::op_e op, logic [3:0] pid, logic [7:0] cnt,
                             int cap);
    int extra;
    send_item(op, pid, cnt);
    while (pl_active && cap > 0) begin
      send_tick();
      cap--;
    end
    extra = $urandom_range(0, 2);
    repeat (extra) send_tick();
  endtask

  // receiver: random stall, or a long hold-off when a test asks for one
  always @(posedge clk_i) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !rx_steady && ($urandom_range(99) < 35);
    end
  end

  task automatic flag_error(string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("%0t: %s", $time, msg);
  endtask

  always @(posedge clk_i) begin
    btps_pkg::res_t want;
    if (rst_ni === 1'b1 && out_valid === 1'b1 && !out_stall) begin
      if (pending_tones.size() == 0) begin
        flag_error($sformatf("unexpected result: hz=%0d on=%0b busy=%0b step=%0d",
                             tone_hz, tone_on, busy_res, step_index));
      end else begin
        want = pending_tones.pop_front();
        if (want.tone_hz !== tone_hz || want.tone_on !== tone_on ||
            want.busy_res !== busy_res || want.step_index !== step_index) begin
          flag_error($sformatf({"mismatch: expected hz=%0d on=%0b busy=%0b step=%0d,",
                                " got hz=%0d on=%0b busy=%0b step=%0d"},
                               want.tone_hz, want.tone_on, want.busy_res, want.step_index,
                               tone_hz, tone_on, busy_res, step_index));
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_directed();
    send_item(btps_pkg::OP_TICK, 4'hF, 8'hFF);      // tick while idle
    send_item(btps_pkg::OP_STOP, 4'h0, 8'h00);
    send_item(btps_pkg::OP_PLAY, 4'd0, 8'hFF);      // invalid pattern ids stop
    send_item(btps_pkg::OP_PLAY, 4'd12, 8'h00);
    send_item(btps_pkg::OP_PLAY, 4'd15, 8'h5A);
    send_item(btps_pkg::OP_PLAY, 4'd1, 8'h00);
    send_tick();
    send_tick();
    send_item(btps_pkg::OP_PLAY, 4'd1, 8'hFF);      // restart from step 0
    send_item(btps_pkg::OP_COUNT, 4'hF, 8'd0);      // zero count stops
    send_item(btps_pkg::OP_COUNT, 4'd0, 8'd1);
    send_tick();
    send_item(btps_pkg::OP_COUNT, 4'd3, 8'd255);    // large count is capped
    send_item(btps_pkg::OP_COUNT, 4'd0, 8'd6);
    send_item(btps_pkg::OP_COUNT, 4'd0, 8'd5);
    send_item(btps_pkg::OP_PLAY, 4'd11, 8'd0);
    send_tick();
    send_item(btps_pkg::OP_PLAY, 4'd6, 8'h80);
    send_item(btps_pkg::OP_STOP, 4'hF, 8'hFF);
    send_tick();
    send_item(btps_pkg::OP_COUNT, 4'd9, 8'd128);
    send_item(btps_pkg::OP_STOP, 4'd0, 8'd0);
    wait_drained();
  endtask

  task automatic test_step_timing();
    play_to_end(btps_pkg::OP_PLAY, 4'd3, 8'd0, 1000);   // tone step then silent step
    play_to_end(btps_pkg::OP_COUNT, 4'd0, 8'd1, 1000);
    wait_drained();
  endtask

  task automatic test_backpressure();
    tx_steady = 1'b1;
    hold_len  = 300;
    hold_req++;
    send_item(btps_pkg::OP_COUNT, 4'($urandom_range(15)), 8'd2);
    repeat (40) send_tick();
    tx_steady = 1'b0;
    wait_drained();
  endtask

  task automatic test_full_rate();
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    play_to_end(btps_pkg::OP_COUNT, 4'($urandom_range(15)), 8'd3, 200);
    play_to_end(btps_pkg::OP_PLAY, 4'd5, 8'($urandom_range(255)), 1000);
    wait_drained();
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  task automatic random_sequence(int room);
    int pick;
    int cap;
    btps_pkg::op_e op;
    logic [3:0] pid;
    logic [7:0] cnt;
    pick = $urandom_range(99);
    pid  = 4'($urandom_range(15));
    cnt  = 8'($urandom_range(255));
    if (pick < 45) begin
      op  = btps_pkg::OP_PLAY;
      pid = 4'($urandom_range(1, PATTERNS - 1));
    end else if (pick < 75) begin
      op = btps_pkg::OP_COUNT;
      if ($urandom_range(99) < 70) cnt = 8'($urandom_range(1, 6));
    end else if (pick < 85) begin
      op  = btps_pkg::OP_PLAY;
      pid = $urandom_range(1) ? 4'd0 : 4'($urandom_range(12, 15));
    end else if (pick < 90) begin
      op  = btps_pkg::OP_COUNT;
      cnt = 8'd0;
    end else begin
      op = btps_pkg::OP_STOP;
    end
    // most runs play out, the rest are cut short by the next command
    cap = ($urandom_range(99) < 60) ? 1200 : $urandom_range(0, 40);
    if (cap > room) cap = room;
    play_to_end(op, pid, cnt, cap);
  endtask

  task automatic test_random();
    int goal;
    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) random_sequence(goal - items_sent);
    wait_drained();
  endtask

  initial begin
    rst_ni     = 1'b0;
    in_valid   = 1'b0;
    opcode     = btps_pkg::OP_TICK;
    pattern_id = '0;
    beep_count = '0;
    pl_count_mode = 1'b0;
    pl_pattern    = '0;
    pl_step       = '0;
    pl_beeps      = '0;
    go_silent();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_step_timing();
    test_backpressure();
    test_full_rate();
    test_random();
    repeat (4) @(posedge clk_i);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
